// ----- src/icmp_erb_pkg.sv -----
// ----------------------------------------------------------------------------
// icmp_erb_pkg
// Shared types, constants and helpers for the icmp echo request builder.
// ----------------------------------------------------------------------------
package icmp_erb_pkg;

  localparam int HDR_BYTES         = 8;
  localparam int MAX_PAYLOAD_BYTES = 504;
  localparam int PATTERN_MAX_BYTES = 16;
  localparam int STAMP_BYTES       = 16;

  localparam int PLEN_W  = 9;   // payload length register width
  localparam int PATL_W  = 5;   // pattern length register width
  localparam int TOTAL_W = 10;  // header plus payload byte count
  localparam int WIDX_W  = 6;   // word index, up to 64 words
  localparam int PHASE_W = 4;   // pattern byte position
  localparam int ACC_W   = 24;  // checksum accumulator before folding

  localparam logic [7:0] ICMP_TYPE_ECHO = 8'd8;
  localparam logic [7:0] ICMP_CODE_ECHO = 8'd0;

  typedef enum logic [2:0] {
    REG_PAYLOAD_LENGTH = 3'd0,
    REG_PATTERN_ENABLE = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_PATTERN_LOW    = 3'd3,
    REG_PATTERN_HIGH   = 3'd4,
    REG_ECHO_ID        = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_FOLD1,
    ST_FOLD2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0] sequence_number;
    logic [63:0] stamp_seconds;
    logic [29:0] stamp_nanoseconds;
  } in_t;

  typedef struct packed {
    logic [63:0] packet_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic [PLEN_W-1:0] payload_length;
    logic              pattern_enable;
    logic [PATL_W-1:0] pattern_length;
    logic [63:0]       pattern_low_bytes;
    logic [63:0]       pattern_high_bytes;
    logic [15:0]       echo_identifier;
  } cfg_t;

  // saturated payload length
  function automatic logic [PLEN_W-1:0] eff_plen(input logic [PLEN_W-1:0] plen);
    if (plen > PLEN_W'(MAX_PAYLOAD_BYTES)) begin
      return PLEN_W'(MAX_PAYLOAD_BYTES);
    end
    return plen;
  endfunction

  // pattern length clamped to 1..max
  function automatic logic [PATL_W-1:0] eff_patlen(input logic [PATL_W-1:0] patlen);
    if (patlen == '0) begin
      return PATL_W'(1);
    end
    if (patlen > PATL_W'(PATTERN_MAX_BYTES)) begin
      return PATL_W'(PATTERN_MAX_BYTES);
    end
    return patlen;
  endfunction

endpackage

// ----- src/icmp_erb_word_gen.sv -----
// ----------------------------------------------------------------------------
// icmp_erb_word_gen
// Builds one 8-byte packet word from its index, the pattern phase and config.
// ----------------------------------------------------------------------------
module icmp_erb_word_gen
  import icmp_erb_pkg::*;
(
  input  cfg_t               cfg,
  input  in_t                item,
  input  logic [WIDX_W-1:0]  word_idx,
  input  logic [PHASE_W-1:0] phase_in,
  input  logic [15:0]        checksum,
  output logic [63:0]        word,
  output logic [3:0]         valid_bytes,
  output logic [PHASE_W-1:0] phase_out
);

  logic [PLEN_W-1:0]  plen;
  logic [PATL_W-1:0]  patlen;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W-1:0] rem;
  logic [TOTAL_W-1:0] pos;
  logic [TOTAL_W-1:0] off;
  logic [PHASE_W-1:0] ph;
  logic [127:0]       pat;
  logic [63:0]        nsec_ext;
  logic               stamp_fits;
  logic [7:0]         byte_v;

  always_comb begin
    plen       = eff_plen(cfg.payload_length);
    patlen     = eff_patlen(cfg.pattern_length);
    total      = TOTAL_W'(HDR_BYTES) + {1'b0, plen};
    base       = {1'b0, word_idx, 3'b000};
    rem        = total - base;
    pat        = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};
    nsec_ext   = {34'd0, item.stamp_nanoseconds};
    stamp_fits = (plen >= PLEN_W'(STAMP_BYTES));
    ph         = phase_in;
    word       = '0;
    pos        = '0;
    off        = '0;
    byte_v     = '0;
    for (int b = 0; b < 8; b++) begin
      pos = base + TOTAL_W'(b);
      off = pos - TOTAL_W'(HDR_BYTES);
      if (word_idx == '0) begin
        byte_v = '0;
      end else if (cfg.pattern_enable) begin
        byte_v = pat[{ph, 3'b000} +: 8];
        ph = ({1'b0, ph} == patlen - PATL_W'(1)) ? '0 : ph + PHASE_W'(1);
      end else if (stamp_fits && word_idx == WIDX_W'(1)) begin
        byte_v = item.stamp_seconds[8*b +: 8];
      end else if (stamp_fits && word_idx == WIDX_W'(2)) begin
        byte_v = nsec_ext[8*b +: 8];
      end else begin
        byte_v = off[7:0];
      end
      if (pos >= total) begin
        byte_v = '0;
      end
      word[63-8*b -: 8] = byte_v;
    end
    // header word: type, code, checksum, identifier, sequence
    if (word_idx == '0) begin
      word = {ICMP_TYPE_ECHO, ICMP_CODE_ECHO, checksum, cfg.echo_identifier,
              item.sequence_number};
    end
    phase_out   = ph;
    valid_bytes = (rem >= TOTAL_W'(8)) ? 4'd8 : rem[3:0];
  end

endmodule

// ----- src/icmp_echo_request_builder_core.sv -----
// ----------------------------------------------------------------------------
// icmp_echo_request_builder_core
// Builds an icmp echo request per probe and streams it as 8-byte words.
// ----------------------------------------------------------------------------
// A probe (sequence number plus send timestamp) is taken when start is high
// and busy is low. The block then makes two passes over the packet with one
// shared word generator: the first pass walks every word once and adds its
// four 16-bit halves into a checksum accumulator, states FOLD1 and FOLD2 fold
// the end carries, and the second pass regenerates the words with the checksum
// in place and puts out one word per cycle on out_data, marked by out_strobe.
// A packet of N words (N = ceil((8 + payload_length) / 8), 1 to 64) keeps busy
// high through both passes and the folds; the last word is on the port once
// busy has dropped, so the next probe may start while it is still shown. Words
// come out in wire order, earliest byte in bits 63:56, unused bytes of the
// final word zero. The receiver cannot stall: each word is on the port for
// exactly one cycle. Registers are written over the apb port at byte address
// 8*index and should only be changed while busy is low and no word is pending.
// ----------------------------------------------------------------------------
module icmp_echo_request_builder_core
  import icmp_erb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // probe input
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  // packet words
  output logic        out_strobe,
  output out_t        out_data,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // register file
  cfg_t     cfg_r, cfg_nxt;
  cfg_reg_t reg_sel;
  logic     cfg_wr;

  // sequencer
  state_t state_r, state_nxt;
  logic   sum_en, fold_en, emit_en;
  logic   last_idx;

  // datapath
  in_t                item_r, item_nxt;
  logic [WIDX_W-1:0]  widx_r, widx_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_t               out_data_r, out_data_nxt;
  logic [WIDX_W-1:0]  words_m1;
  logic [TOTAL_W-1:0] total_m1;

  // word generator
  logic [15:0]        gen_ck;
  logic [63:0]        gen_word;
  logic [3:0]         gen_valid;
  logic [PHASE_W-1:0] gen_phase;
  logic [17:0]        half_sum;

  // --------------------------------------------------------------------------
  // register port: always ready, write on the access cycle
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_PAYLOAD_LENGTH: cfg_nxt.payload_length     = pwdata[PLEN_W-1:0];
        REG_PATTERN_ENABLE: cfg_nxt.pattern_enable     = pwdata[0];
        REG_PATTERN_LENGTH: cfg_nxt.pattern_length     = pwdata[PATL_W-1:0];
        REG_PATTERN_LOW:    cfg_nxt.pattern_low_bytes  = pwdata;
        REG_PATTERN_HIGH:   cfg_nxt.pattern_high_bytes = pwdata;
        REG_ECHO_ID:        cfg_nxt.echo_identifier    = pwdata[15:0];
        default:            cfg_nxt = cfg_r;  // unmapped index, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAYLOAD_LENGTH: prdata = {55'd0, cfg_r.payload_length};
      REG_PATTERN_ENABLE: prdata = {63'd0, cfg_r.pattern_enable};
      REG_PATTERN_LENGTH: prdata = {59'd0, cfg_r.pattern_length};
      REG_PATTERN_LOW:    prdata = cfg_r.pattern_low_bytes;
      REG_PATTERN_HIGH:   prdata = cfg_r.pattern_high_bytes;
      REG_ECHO_ID:        prdata = {48'd0, cfg_r.echo_identifier};
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // packet geometry: index of the final word
  // --------------------------------------------------------------------------
  assign total_m1 = TOTAL_W'(HDR_BYTES - 1) + {1'b0, eff_plen(cfg_r.payload_length)};
  assign words_m1 = total_m1[TOTAL_W-2:3];
  assign last_idx = (widx_r == words_m1);

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) begin
                  state_nxt = ST_SUM;
                end
      ST_SUM:   if (last_idx) begin
                  state_nxt = ST_FOLD1;
                end
      ST_FOLD1: state_nxt = ST_FOLD2;
      ST_FOLD2: state_nxt = ST_EMIT;
      ST_EMIT:  if (last_idx) begin
                  state_nxt = ST_IDLE;
                end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: control outputs
  always_comb begin
    busy    = 1'b1;
    sum_en  = 1'b0;
    fold_en = 1'b0;
    emit_en = 1'b0;
    unique case (state_r)
      ST_IDLE:  busy    = 1'b0;
      ST_SUM:   sum_en  = 1'b1;
      ST_FOLD1: fold_en = 1'b1;
      ST_FOLD2: fold_en = 1'b1;
      ST_EMIT:  emit_en = 1'b1;
      default:  busy    = 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // shared word generator; checksum field reads zero on the summing pass
  // --------------------------------------------------------------------------
  assign gen_ck = emit_en ? ~acc_r[15:0] : 16'd0;

  icmp_erb_word_gen u_word_gen (
    .cfg         (cfg_r),
    .item        (item_r),
    .word_idx    (widx_r),
    .phase_in    (phase_r),
    .checksum    (gen_ck),
    .word        (gen_word),
    .valid_bytes (gen_valid),
    .phase_out   (gen_phase)
  );

  assign half_sum = 18'(gen_word[63:48]) + 18'(gen_word[47:32])
                  + 18'(gen_word[31:16]) + 18'(gen_word[15:0]);

  // --------------------------------------------------------------------------
  // datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    item_nxt       = item_r;
    widx_nxt       = widx_r;
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;

    if (!busy && start) begin
      item_nxt  = in_data;
      widx_nxt  = '0;
      phase_nxt = '0;
      acc_nxt   = '0;
    end

    // pattern phase only advances across payload words
    if (sum_en || emit_en) begin
      widx_nxt = widx_r + WIDX_W'(1);
      if (widx_r != '0) begin
        phase_nxt = gen_phase;
      end
    end

    if (sum_en) begin
      acc_nxt = acc_r + ACC_W'(half_sum);
    end

    // end-around carry, two folds bring it under 16 bits
    if (fold_en) begin
      acc_nxt   = ACC_W'(acc_r[15:0]) + ACC_W'(acc_r[ACC_W-1:16]);
      widx_nxt  = '0;
      phase_nxt = '0;
    end

    if (emit_en) begin
      out_strobe_nxt           = 1'b1;
      out_data_nxt.packet_word = gen_word;
      out_data_nxt.valid_bytes = gen_valid;
      out_data_nxt.last_word   = last_idx;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                    <= ST_IDLE;
      out_strobe_r               <= 1'b0;
      cfg_r.payload_length       <= PLEN_W'(56);
      cfg_r.pattern_enable       <= 1'b0;
      cfg_r.pattern_length       <= PATL_W'(1);
      cfg_r.pattern_low_bytes    <= '0;
      cfg_r.pattern_high_bytes   <= '0;
      cfg_r.echo_identifier      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      cfg_r        <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    widx_r     <= widx_nxt;
    phase_r    <= phase_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
